/* rtl/uart_rb_pkg.sv */
// ----------------------------------------------------------------------------
// uart_rb_pkg
// Shared types and constants for the buffered UART receive/transmit rings.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    CMD_RECEIVE = 2'd0,
    CMD_READ    = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_TX_DONE = 2'd3
  } cmd_t;

  // request into the receive ring
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] data;
  } rx_req_t;

  // receive ring status
  typedef struct packed {
    logic              popped;
    logic              overflow;
    logic [BYTE_W-1:0] fill;
  } rx_stat_t;

  // request into the transmit ring
  typedef struct packed {
    logic              write;
    logic              done;
    logic              tre;
    logic [BYTE_W-1:0] data;
  } tx_req_t;

  // transmit ring status
  typedef struct packed {
    logic              accepted;
    logic              direct;
    logic              popped;
    logic [BYTE_W-1:0] fill;
  } tx_stat_t;

endpackage

/* rtl/uart_buffered_rx_tx_fifo.sv */
// ----------------------------------------------------------------------------
// uart_buffered_rx_tx_fifo
// Buffered UART receive and transmit rings with a request/result interface.
// ----------------------------------------------------------------------------
// Each request (byte received, software read, software write or transmit
// complete) is taken and its result appears on the output register in the
// next cycle; a new request is accepted every cycle as long as the output
// side is not stalling a held result. The registered read port of the ring
// RAMs keeps pace with the output register and feeds read_data and queued
// send_byte directly. Fill counts and the overflow flag show the state
// after the request in the result. There is no clearing pass after reset.
module uart_buffered_rx_tx_fifo import uart_rb_pkg::*; #(
  parameter int RECEIVE_DEPTH  = 128,
  parameter int TRANSMIT_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              frame_error,
  input  logic              parity_fault,
  input  logic              overrun_error,
  input  logic              transmit_register_empty,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] read_data,
  output logic              read_valid,
  output logic [BYTE_W-1:0] send_byte,
  output logic              send_valid,
  output logic              write_accepted,
  output logic [BYTE_W-1:0] receive_fill,
  output logic [BYTE_W-1:0] transmit_fill,
  output logic              overflow_flag
);

  cmd_t              cmd;
  logic              advance;
  logic              out_valid_next;
  rx_req_t           rx_req;
  rx_stat_t          rx_stat;
  tx_req_t           tx_req;
  tx_stat_t          tx_stat;
  logic [BYTE_W-1:0] rx_rdata;
  logic [BYTE_W-1:0] tx_rdata;

  logic              read_hit;
  logic              send_hit;
  logic              send_queued;
  logic              write_ok;
  logic [BYTE_W-1:0] direct_byte;

  assign cmd      = cmd_t'(command);
  assign in_stall = out_valid && out_stall;
  assign advance  = in_valid && !in_stall;

  always_comb begin
    rx_req      = '0;
    tx_req      = '0;
    rx_req.data = data_byte;
    tx_req.data = data_byte;
    tx_req.tre  = transmit_register_empty;
    if (advance) begin
      unique case (cmd)
        CMD_RECEIVE: rx_req.push = !(frame_error || parity_fault || overrun_error);
        CMD_READ:    rx_req.pop  = 1'b1;
        CMD_WRITE:   tx_req.write = 1'b1;
        CMD_TX_DONE: tx_req.done = 1'b1;
        default:     rx_req.pop  = 1'b0;
      endcase
    end
  end

  uart_rb_rx_ring #(
    .DEPTH (RECEIVE_DEPTH)
  ) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (rx_req),
    .stat  (rx_stat),
    .rdata (rx_rdata)
  );

  uart_rb_tx_ring #(
    .DEPTH (TRANSMIT_DEPTH)
  ) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .req   (tx_req),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  always_comb begin
    if (advance) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_hit    <= rx_stat.popped;
      send_hit    <= tx_stat.direct || tx_stat.popped;
      send_queued <= tx_stat.popped;
      write_ok    <= tx_stat.accepted;
      direct_byte <= data_byte;
    end
  end

  // ring state only moves on an accepted request, so it matches the held result
  assign read_data      = read_hit ? rx_rdata : '0;
  assign read_valid     = read_hit;
  assign send_byte      = !send_hit ? '0 : (send_queued ? tx_rdata : direct_byte);
  assign send_valid     = send_hit;
  assign write_accepted = write_ok;
  assign receive_fill   = rx_stat.fill;
  assign transmit_fill  = tx_stat.fill;
  assign overflow_flag  = rx_stat.overflow;

endmodule

/* rtl/uart_rb_ram.sv */
// ----------------------------------------------------------------------------
// uart_rb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uart_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data unless a read is requested
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/uart_rb_rx_ring.sv */
// ----------------------------------------------------------------------------
// uart_rb_rx_ring
// Receive ring: stores good bytes, pops on software read, wraps the count
// to zero on overflow and keeps a sticky overflow flag.
// ----------------------------------------------------------------------------
module uart_rb_rx_ring import uart_rb_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  rx_req_t           req,
  output rx_stat_t          stat,
  output logic [BYTE_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0]     LAST_PTR = AW'(DEPTH - 1);
  localparam logic [BYTE_W-1:0] LAST_CNT = BYTE_W'(DEPTH - 1);

  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [BYTE_W-1:0] count, count_next;
  logic              overflow, overflow_next;
  logic              pop;

  assign pop = req.pop && (count != '0);

  always_comb begin
    wr_ptr_next   = wr_ptr;
    rd_ptr_next   = rd_ptr;
    count_next    = count;
    overflow_next = overflow;
    if (req.push) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      // drop the count to zero when a push fills the last free slot
      if (count == LAST_CNT) begin
        count_next    = '0;
        overflow_next = 1'b1;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  uart_rb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.push),
    .waddr (wr_ptr),
    .wdata (req.data),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_comb begin
    stat.popped   = pop;
    stat.overflow = overflow;
    stat.fill     = count;
  end

endmodule

/* rtl/uart_rb_tx_ring.sv */
// ----------------------------------------------------------------------------
// uart_rb_tx_ring
// Transmit ring: passes a write straight to the transmitter when possible,
// else queues it unless full, and hands queued bytes on at transmit complete.
// ----------------------------------------------------------------------------
module uart_rb_tx_ring import uart_rb_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  tx_req_t           req,
  output tx_stat_t          stat,
  output logic [BYTE_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0]     LAST_PTR = AW'(DEPTH - 1);
  localparam logic [BYTE_W-1:0] FULL_CNT = BYTE_W'(DEPTH);

  logic [AW-1:0]     wr_ptr, wr_ptr_next;
  logic [AW-1:0]     rd_ptr, rd_ptr_next;
  logic [BYTE_W-1:0] count, count_next;
  logic              accepted, direct, enqueue, pop;

  assign accepted = req.write && (count != FULL_CNT);
  // bypass the ring when it is empty and the data register is free
  assign direct   = accepted && (count == '0) && req.tre;
  assign enqueue  = accepted && !direct;
  assign pop      = req.done && (count != '0);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (enqueue) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      count_next  = count + 1'b1;
    end else if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      count_next  = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  uart_rb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (enqueue),
    .waddr (wr_ptr),
    .wdata (req.data),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  always_comb begin
    stat.accepted = accepted;
    stat.direct   = direct;
    stat.popped   = pop;
    stat.fill     = count;
  end

endmodule

/* rtl/uart_rb_checker.sv */
// ----------------------------------------------------------------------------
// uart_rb_checker
// Port-level checks for the buffered UART rings, bound to the top level.
// ----------------------------------------------------------------------------
module uart_rb_checker import uart_rb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] read_data,
  input logic              read_valid,
  input logic [BYTE_W-1:0] send_byte,
  input logic              send_valid,
  input logic              write_accepted,
  input logic              overflow_flag
);

  // a held result keeps its payload
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(send_byte)))
    else $error("result changed while stalled");

  // a read result never reports transmit activity
  a_read_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_valid) |-> !(send_valid || write_accepted))
    else $error("read result mixed with transmit activity");

  // data fields are zero when their valid is low
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((read_valid || read_data == '0) && (send_valid || send_byte == '0)))
    else $error("data field nonzero without valid");

  // overflow stays set until reset
  a_sticky_overflow: assert property (@(posedge clk)
    (overflow_flag && !rst) |=> overflow_flag)
    else $error("overflow flag cleared without reset");

endmodule

bind uart_buffered_rx_tx_fifo uart_rb_checker u_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffered UART receive/transmit rings.
// A short table of directed requests walks the corner cases (empty reads,
// discarded bytes, direct and queued sends). Random phases then flood and
// drain each ring to reach receive overflow and transmit-full rejection.
// Each result is checked against its typed row or a local model of both rings.
// ----------------------------------------------------------------------------
module tb;
  import uart_rb_pkg::*;

  localparam int RX_DEPTH       = 128;
  localparam int TX_DEPTH       = 128;
  localparam int PHASE_ITEMS    = 200;
  localparam int NUM_PHASES     = 9;
  localparam int QUIET_PHASE    = 7;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] rd;
    logic       rv;
    logic [7:0] sb;
    logic       sv;
    logic       wa;
    logic [7:0] rf;
    logic [7:0] tf;
    logic       of;
  } uart_result_t;

  typedef struct packed {
    cmd_t         cmd;
    logic [7:0]   data;
    logic         fe;
    logic         pe;
    logic         oe;
    logic         tre;
    logic         typed;
    uart_result_t res;
  } stim_row_t;

  typedef enum int {
    MODE_MIX,
    MODE_RX_FLOOD,
    MODE_TX_FLOOD,
    MODE_RX_DRAIN,
    MODE_TX_DRAIN
  } mode_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_READ;
  logic [7:0] data_byte = 8'h00;
  logic       frame_error = 1'b0;
  logic       parity_fault = 1'b0;
  logic       overrun_error = 1'b0;
  logic       transmit_register_empty = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       read_valid;
  logic [7:0] send_byte;
  logic       send_valid;
  logic       write_accepted;
  logic [7:0] receive_fill;
  logic [7:0] transmit_fill;
  logic       overflow_flag;

  uart_buffered_rx_tx_fifo #(
    .RECEIVE_DEPTH (RX_DEPTH),
    .TRANSMIT_DEPTH(TX_DEPTH)
  ) dut (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .command                (command),
    .data_byte              (data_byte),
    .frame_error            (frame_error),
    .parity_fault           (parity_fault),
    .overrun_error          (overrun_error),
    .transmit_register_empty(transmit_register_empty),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .read_data              (read_data),
    .read_valid             (read_valid),
    .send_byte              (send_byte),
    .send_valid             (send_valid),
    .write_accepted         (write_accepted),
    .receive_fill           (receive_fill),
    .transmit_fill          (transmit_fill),
    .overflow_flag          (overflow_flag)
  );

  // Ring model state
  logic [7:0] rx_ring [RX_DEPTH];
  logic [7:0] rx_wr = '0;
  logic [7:0] rx_rd = '0;
  logic [7:0] rx_count = '0;
  logic       rx_overflow = 1'b0;
  logic [7:0] tx_ring [TX_DEPTH];
  logic [7:0] tx_wr = '0;
  logic [7:0] tx_rd = '0;
  logic [7:0] tx_count = '0;

  uart_result_t uart_results_q[$];
  stim_row_t    cur_row = '0;
  bit           quiet_run = 1'b0;
  int           errors = 0;
  int           idle_cycles = 0;
  int           n_requests = 0;
  int           n_checked = 0;
  int           n_pops = 0;
  int           n_direct = 0;
  int           n_rejects = 0;

  // rd rv sb sv wa rf tf of
  stim_row_t directed_rows [18] = '{
    '{CMD_READ,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_TX_DONE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'h55, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'd0, 1'b0}},
    '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd2, 8'd0, 1'b0}},
    '{CMD_READ,    8'hAA, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
      '{8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'd1, 8'd0, 1'b0}},
    '{CMD_READ,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      '{8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_READ,    8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{CMD_WRITE,   8'hA5, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, 8'hA5, 1'b1, 1'b1, 8'd0, 8'd0, 1'b0}},
    '{CMD_WRITE,   8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_WRITE,   8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_TX_DONE, 8'h33, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_WRITE,   8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0}
  };

  mode_t phase_plan [NUM_PHASES] = '{
    MODE_MIX, MODE_RX_FLOOD, MODE_TX_FLOOD, MODE_RX_DRAIN, MODE_TX_DRAIN,
    MODE_RX_FLOOD, MODE_TX_FLOOD, MODE_MIX, MODE_RX_DRAIN
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance both rings by one request and return the result it owes.
  function automatic uart_result_t step_uart_rings(cmd_t c, logic [7:0] d, logic err,
                                                   logic tre);
    uart_result_t r;
    r = '0;
    case (c)
      CMD_RECEIVE: begin
        if (!err) begin
          rx_ring[rx_wr] = d;
          rx_wr = (rx_wr == RX_DEPTH - 1) ? 8'd0 : rx_wr + 8'd1;
          rx_count = rx_count + 8'd1;
          // overflow wraps the count but leaves the pointers moving
          if (rx_count >= RX_DEPTH) begin
            rx_count = '0;
            rx_overflow = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (rx_count != 0) begin
          r.rd = rx_ring[rx_rd];
          r.rv = 1'b1;
          rx_rd = (rx_rd == RX_DEPTH - 1) ? 8'd0 : rx_rd + 8'd1;
          rx_count = rx_count - 8'd1;
        end
      end
      CMD_WRITE: begin
        if (tx_count < TX_DEPTH) begin
          r.wa = 1'b1;
          if (tx_count != 0 || !tre) begin
            tx_ring[tx_wr] = d;
            tx_wr = (tx_wr == TX_DEPTH - 1) ? 8'd0 : tx_wr + 8'd1;
            tx_count = tx_count + 8'd1;
          end else begin
            r.sb = d;
            r.sv = 1'b1;
          end
        end
      end
      default: begin
        if (tx_count != 0) begin
          tx_count = tx_count - 8'd1;
          r.sb = tx_ring[tx_rd];
          r.sv = 1'b1;
          tx_rd = (tx_rd == TX_DEPTH - 1) ? 8'd0 : tx_rd + 8'd1;
        end
      end
    endcase
    r.rf = rx_count;
    r.tf = tx_count;
    r.of = rx_overflow;
    return r;
  endfunction

  function automatic stim_row_t draw_request(mode_t mode);
    stim_row_t  r;
    int         roll;
    logic [2:0] flags;
    r = '0;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_RX_FLOOD: r.cmd = (roll < 85) ? CMD_RECEIVE : cmd_t'($urandom_range(0, 3));
      MODE_TX_FLOOD: r.cmd = (roll < 85) ? CMD_WRITE : cmd_t'($urandom_range(0, 3));
      MODE_RX_DRAIN: r.cmd = (roll < 80) ? CMD_READ : cmd_t'($urandom_range(0, 3));
      MODE_TX_DRAIN: r.cmd = (roll < 80) ? CMD_TX_DONE : cmd_t'($urandom_range(0, 3));
      default:       r.cmd = cmd_t'($urandom_range(0, 3));
    endcase
    r.data = 8'($urandom_range(0, 255));
    // keep most received bytes clean so the ring actually fills
    if (r.cmd == CMD_RECEIVE)
      flags = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    else
      flags = 3'($urandom_range(0, 7));
    {r.fe, r.pe, r.oe} = flags;
    r.tre = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(input stim_row_t r);
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid                <= 1'b1;
    command                 <= r.cmd;
    data_byte               <= r.data;
    frame_error             <= r.fe;
    parity_fault            <= r.pe;
    overrun_error           <= r.oe;
    transmit_register_empty <= r.tre;
    cur_row                 <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (uart_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    uart_result_t pred;
    uart_result_t exp_res;
    bit           moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_requests++;
        pred = step_uart_rings(cmd_t'(command), data_byte,
                               frame_error | parity_fault | overrun_error,
                               transmit_register_empty);
        if (pred.rv) n_pops++;
        if (pred.sv && cmd_t'(command) == CMD_WRITE) n_direct++;
        if (cmd_t'(command) == CMD_WRITE && !pred.wa) n_rejects++;
        uart_results_q.push_back(cur_row.typed ? cur_row.res : pred);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (uart_results_q.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          errors++;
        end else begin
          exp_res = uart_results_q.pop_front();
          n_checked++;
          check_field("read_data", exp_res.rd, read_data);
          check_field("read_valid", exp_res.rv, read_valid);
          check_field("send_byte", exp_res.sb, send_byte);
          check_field("send_valid", exp_res.sv, send_valid);
          check_field("write_accepted", exp_res.wa, write_accepted);
          check_field("receive_fill", exp_res.rf, receive_fill);
          check_field("transmit_fill", exp_res.tf, transmit_fill);
          check_field("overflow_flag", exp_res.of, overflow_flag);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Result side back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && !quiet_run && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stim_row_t r;
    int        done;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    wait_results_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet_run = (p >= QUIET_PHASE);
      done = 0;
      while (done < PHASE_ITEMS) begin
        r = draw_request(phase_plan[p]);
        send_request(r);
        // discarded bytes do not count toward the phase
        if (!(r.cmd == CMD_RECEIVE && (r.fe | r.pe | r.oe))) done++;
      end
      // hold off until the block has answered everything
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests, %0d results checked: %0d bytes read, %0d direct sends,",
             n_requests, n_checked, n_pops, n_direct);
    $display("%0d writes rejected on a full ring, receive overflow seen: %0d",
             n_rejects, rx_overflow);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
